### hdl/throttle_deadzone_expo_shaper_assert.svh
// Assertion macros shared by the throttle shaper RTL.
`ifndef THROTTLE_DEADZONE_EXPO_SHAPER_ASSERT_SVH
`define THROTTLE_DEADZONE_EXPO_SHAPER_ASSERT_SVH

// Same-cycle implication, sampled on clk and muted during rst.
`define TDES_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted during rst.
`define TDES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tdes_pkg.sv
// Shared constants, register codes and types of the throttle shaper.
package tdes_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int LIMIT_W  = 15;
  localparam int CLEAN_W  = 16;
  localparam int THR_W    = 31;
  localparam int IDX_W    = 3;

  // Divider geometry: 30-bit dividend (a 15 by 15 product), 16-bit divisor.
  localparam int DIV_W = 30;
  localparam int DVS_W = 16;

  // ceil(2^33 / 3): exact quotient by three for any 32-bit unsigned value.
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  localparam logic [CFG_W-1:0]        CENTER_RST    = 16'd2048;
  localparam logic [CFG_W-1:0]        DEAD_ZONE_RST = 16'd0;
  localparam logic [CFG_W-1:0]        FULL_SCALE_RST = 16'd4095;
  localparam logic [LIMIT_W-1:0]      FWD_LIMIT_RST = 15'd1000;
  localparam logic signed [CFG_W-1:0] REV_LIMIT_RST = -16'sd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER     = 3'd0,
    REG_DEAD_ZONE  = 3'd1,
    REG_FULL_SCALE = 3'd2,
    REG_FWD_LIMIT  = 3'd3,
    REG_REV_LIMIT  = 3'd4
  } cfg_reg_t;

  // Item flags and payload that ride alongside a division.
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic             zero;
    logic [CFG_W-1:0] val;
  } side_t;

endpackage

### hdl/throttle_deadzone_expo_shaper.sv
// Top level of the throttle shaper: dead zone, scaling and expo curve.
//
// Input channel: in_valid, in_stall, sample. An item is taken at a clock edge
// with in_valid high and in_stall low. Output channel: out_valid, out_stall,
// cleaned_value, throttle_value, bad_config, one result per input item, in order.
// Registers are written through cfg_write, cfg_index and cfg_data; the user must
// write them only while the block is empty, which the block does not enforce.
// Throughput is one item per cycle while out_stall does not hold the pipeline.
// The path runs through the two 30-stage restoring dividers (scaling span and
// curve limit) plus the subtract, multiply and divide-by-three stages.
// When out_stall holds back a finished result the whole pipeline freezes and a
// one-item skid register still takes the next item; in_stall is that register's
// full flag. Synchronous rst empties the pipeline and skid and restores the
// register reset values; no clearing pass is needed.
`include "throttle_deadzone_expo_shaper_assert.svh"

module throttle_deadzone_expo_shaper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tdes_pkg::SAMPLE_W-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tdes_pkg::CLEAN_W-1:0] cleaned_value,
  output logic signed [tdes_pkg::THR_W-1:0]   throttle_value,
  output logic                                bad_config,
  input  logic                                cfg_write,
  input  logic [tdes_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tdes_pkg::CFG_W-1:0]          cfg_data
);

  // Configuration registers.
  logic [15:0]        center_value;
  logic [15:0]        dead_zone_width;
  logic [15:0]        full_scale;
  logic [14:0]        forward_limit;
  logic signed [15:0] reverse_limit;

  // Values derived from configuration, refreshed every cycle.
  logic [17:0]        dz3;
  logic signed [17:0] span_full;
  logic [14:0]        cfg_half;
  logic [14:0]        cfg_span;
  logic               cfg_bad;
  logic [15:0]        rev_mag;
  logic               rev_neg;

  logic adv;
  logic accept;

  logic        sk_valid;
  logic [15:0] sk_sample;

  logic        s0_valid;
  logic [15:0] s0_sample;

  logic [16:0] diff;
  logic [16:0] diff_neg;
  logic        s1_valid;
  logic        s1_neg;
  logic [15:0] s1_mag;

  logic        in_zone;
  logic [15:0] m_full;
  logic        s2_valid;
  logic        s2_neg;
  logic        s2_sat;
  logic        s2_zero;
  logic [14:0] s2_m;

  logic [29:0]     prod1;
  logic            s3_valid;
  logic [29:0]     s3_prod;
  tdes_pkg::side_t s3_side;

  logic            d1_valid;
  logic [29:0]     d1_quo;
  tdes_pkg::side_t d1_side;

  logic [14:0] cmag;
  logic        s4_valid;
  logic [14:0] s4_cmag;
  logic        s4_neg;

  logic            s5_valid;
  logic [29:0]     s5_sq;
  logic [15:0]     s5_dvs;
  tdes_pkg::side_t s5_side;

  logic            d2_valid;
  logic [29:0]     d2_quo;
  tdes_pkg::side_t d2_side;

  logic [32:0] twice;
  logic [32:0] term;
  logic        s6_valid;
  logic [32:0] s6_sum;
  logic [15:0] s6_c;

  logic [32:0] sum_neg;
  logic        s7_valid;
  logic        s7_neg;
  logic [31:0] s7_mag;
  logic [15:0] s7_c;

  logic        s8_valid;
  logic        s8_neg;
  logic [63:0] s8_prod;
  logic [15:0] s8_c;

  logic [30:0] q3;
  logic [30:0] thr;

  // ---------------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_value    <= tdes_pkg::CENTER_RST;
      dead_zone_width <= tdes_pkg::DEAD_ZONE_RST;
      full_scale      <= tdes_pkg::FULL_SCALE_RST;
      forward_limit   <= tdes_pkg::FWD_LIMIT_RST;
      reverse_limit   <= tdes_pkg::REV_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tdes_pkg::REG_CENTER:     center_value    <= cfg_data;
        tdes_pkg::REG_DEAD_ZONE:  dead_zone_width <= cfg_data;
        tdes_pkg::REG_FULL_SCALE: full_scale      <= cfg_data;
        tdes_pkg::REG_FWD_LIMIT:  forward_limit   <= cfg_data[14:0];
        tdes_pkg::REG_REV_LIMIT:  reverse_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // span = full_scale/2 - (3*dead_zone_width)/2, which may go negative.
  always_comb begin
    dz3       = {2'b00, dead_zone_width} + {1'b0, dead_zone_width, 1'b0};
    span_full = $signed({3'b000, full_scale[15:1]}) - $signed({1'b0, dz3[17:1]});
  end

  always_ff @(posedge clk) begin
    cfg_half <= dead_zone_width[15:1];
    cfg_span <= span_full[14:0];
    cfg_bad  <= span_full[17] || (span_full == 18'sd0) || (forward_limit == 15'd0) ||
                (reverse_limit == 16'sd0);
    rev_mag  <= reverse_limit[15] ? 16'(-reverse_limit) : reverse_limit;
    rev_neg  <= reverse_limit[15];
  end

  // ---------------------------------------------------------------------------
  // Flow control: the pipeline moves unless a finished result is held back.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = sk_valid;
  assign accept   = in_valid && !sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_valid <= 1'b0;
    end else if (adv) begin
      sk_valid <= 1'b0;
    end else if (accept) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && accept) begin
      sk_sample <= sample;
    end
  end

  // Valid bits of the stages outside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= sk_valid || in_valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= d1_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= d2_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      out_valid <= s8_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: center, dead zone, saturation test, scaling product.
  always_comb begin
    diff     = {1'b0, s0_sample} - {1'b0, center_value};
    diff_neg = -diff;
    in_zone  = s1_mag < {1'b0, cfg_half};
    m_full   = s1_mag - {1'b0, cfg_half};
    prod1    = {15'd0, s2_m} * {15'd0, forward_limit};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sample <= sk_valid ? sk_sample : sample;

      s1_neg <= diff[16];
      s1_mag <= diff[16] ? diff_neg[15:0] : diff[15:0];

      s2_neg  <= s1_neg;
      s2_zero <= in_zone;
      s2_sat  <= m_full > {1'b0, cfg_span};
      s2_m    <= m_full[14:0];

      s3_prod      <= prod1;
      s3_side.neg  <= s2_neg;
      s3_side.sat  <= s2_sat;
      s3_side.zero <= s2_zero;
      s3_side.val  <= '0;
    end
  end

  // (|x| - half_zone) * forward_limit / span
  tdes_div u_scale_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s3_valid),
    .dividend  (s3_prod),
    .divisor   ({1'b0, cfg_span}),
    .in_side   (s3_side),
    .out_valid (d1_valid),
    .quotient  (d1_quo),
    .out_side  (d1_side)
  );

  // ---------------------------------------------------------------------------
  // Cleaned value, then square and pick the curve limit by its sign.
  always_comb begin
    if (d1_side.zero) begin
      cmag = '0;
    end else if (d1_side.sat) begin
      cmag = forward_limit;
    end else begin
      cmag = d1_quo[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmag <= cmag;
      s4_neg  <= d1_side.neg && (cmag != 15'd0);

      s5_sq        <= {15'd0, s4_cmag} * {15'd0, s4_cmag};
      s5_dvs       <= s4_neg ? rev_mag : {1'b0, forward_limit};
      s5_side.neg  <= s4_neg && rev_neg;
      s5_side.sat  <= 1'b0;
      s5_side.zero <= 1'b0;
      s5_side.val  <= s4_neg ? 16'(-{1'b0, s4_cmag}) : {1'b0, s4_cmag};
    end
  end

  // cleaned^2 / |limit|; the sign of the limit travels in side.neg.
  tdes_div u_curve_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s5_valid),
    .dividend  (s5_sq),
    .divisor   (s5_dvs),
    .in_side   (s5_side),
    .out_valid (d2_valid),
    .quotient  (d2_quo),
    .out_side  (d2_side)
  );

  // ---------------------------------------------------------------------------
  // Back end: 2*q + c, then divide by three toward zero via sign and magnitude.
  always_comb begin
    twice   = {2'b00, d2_quo, 1'b0};
    term    = d2_side.neg ? -twice : twice;
    sum_neg = -s6_sum;
    q3      = s8_prod[63:33];
    thr     = s8_neg ? -q3 : q3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sum <= term + {{17{d2_side.val[15]}}, d2_side.val};
      s6_c   <= d2_side.val;

      s7_neg <= s6_sum[32];
      s7_mag <= s6_sum[32] ? sum_neg[31:0] : s6_sum[31:0];
      s7_c   <= s6_c;

      s8_neg  <= s7_neg;
      s8_prod <= {32'd0, s7_mag} * {32'd0, tdes_pkg::RECIP3};
      s8_c    <= s7_c;

      // A bad configuration forces zero results whatever the datapath held.
      cleaned_value  <= cfg_bad ? '0 : s8_c;
      throttle_value <= cfg_bad ? '0 : thr;
      bad_config     <= cfg_bad;
    end
  end

  // ---------------------------------------------------------------------------
  `TDES_ASSERT_IMPLIES(a_bad_gives_zero, out_valid && bad_config, (cleaned_value == 16'sd0) && (throttle_value == 31'sd0), "bad configuration result is not zero")
  `TDES_ASSERT_IMPLIES(a_zero_curve, out_valid && (cleaned_value == 16'sd0), throttle_value == 31'sd0, "curve of zero is not zero")
  `TDES_ASSERT_IMPLIES(a_forward_sign, out_valid && !cleaned_value[15] && (cleaned_value != 16'sd0), !throttle_value[30], "forward stick gave a negative throttle")
  `TDES_ASSERT_NEXT(a_skid_holds, sk_valid && !adv, sk_valid, "skid item dropped while pipeline frozen")

endmodule

### hdl/tdes_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tdes_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [tdes_pkg::DIV_W-1:0]   dividend,
  input  logic [tdes_pkg::DVS_W-1:0]   divisor,
  input  tdes_pkg::side_t              in_side,
  output logic                         out_valid,
  output logic [tdes_pkg::DIV_W-1:0]   quotient,
  output tdes_pkg::side_t              out_side
);

  logic                       vld [0:tdes_pkg::DIV_W];
  logic [tdes_pkg::DIV_W-1:0] rem [0:tdes_pkg::DIV_W];
  logic [tdes_pkg::DIV_W-1:0] quo [0:tdes_pkg::DIV_W];
  logic [tdes_pkg::DVS_W-1:0] dvs [0:tdes_pkg::DIV_W];
  tdes_pkg::side_t            sd  [0:tdes_pkg::DIV_W];

  assign vld[0] = in_valid;
  assign rem[0] = dividend;
  assign quo[0] = '0;
  assign dvs[0] = divisor;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < tdes_pkg::DIV_W; k++) begin : g_stage
    localparam int SH = tdes_pkg::DIV_W - 1 - k;
    logic [tdes_pkg::DIV_W-1:0] dvs_ext;
    logic                       hit;
    logic [tdes_pkg::DIV_W-1:0] rem_next;

    // Stage k settles quotient bit SH; the remainder stays below divisor << (SH + 1).
    always_comb begin
      dvs_ext  = {{(tdes_pkg::DIV_W - tdes_pkg::DVS_W){1'b0}}, dvs[k]};
      hit      = (rem[k] >> SH) >= dvs_ext;
      rem_next = hit ? (rem[k] - (dvs_ext << SH)) : rem[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= rem_next;
        quo[k+1] <= {quo[k][tdes_pkg::DIV_W-2:0], hit};
        dvs[k+1] <= dvs[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[tdes_pkg::DIV_W];
  assign quotient  = quo[tdes_pkg::DIV_W];
  assign out_side  = sd[tdes_pkg::DIV_W];

endmodule

### sim/tb_throttle_deadzone_expo_shaper.sv
// Self-checking testbench for the throttle shaper: directed edge cases, then random streams.
`timescale 1ns / 100ps

module tb_throttle_deadzone_expo_shaper;

  localparam int GAP_MAX     = 17;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 75;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [tdes_pkg::IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
  localparam logic [tdes_pkg::IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic signed [tdes_pkg::CLEAN_W-1:0] cleaned;
    logic signed [tdes_pkg::THR_W-1:0]   throttle;
    logic                                bad;
  } shape_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [tdes_pkg::SAMPLE_W-1:0]       sample;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [tdes_pkg::CLEAN_W-1:0] cleaned_value;
  logic signed [tdes_pkg::THR_W-1:0]   throttle_value;
  logic                                bad_config;
  logic                                cfg_write;
  logic [tdes_pkg::IDX_W-1:0]          cfg_index;
  logic [tdes_pkg::CFG_W-1:0]          cfg_data;

  // Local copy of the register file.
  logic [tdes_pkg::CFG_W-1:0]          center_q;
  logic [tdes_pkg::CFG_W-1:0]          dz_q;
  logic [tdes_pkg::CFG_W-1:0]          fs_q;
  logic [tdes_pkg::LIMIT_W-1:0]        fwd_q;
  logic signed [tdes_pkg::CFG_W-1:0]   rev_q;

  shape_t pending_shapes[$];
  shape_t seen_shape;
  shape_t want_shape;

  int in_gap_max  = GAP_MAX;
  int out_gap_max = GAP_MAX;
  int stall_left  = 0;
  int idle_cycles = 0;
  int mismatches  = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_settings  = 1;
  int n_bad       = 0;
  int n_zero      = 0;
  int n_sat       = 0;

  throttle_deadzone_expo_shaper i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cleaned_value  (cleaned_value),
    .throttle_value (throttle_value),
    .bad_config     (bad_config),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic shape_t shape_sample(logic [tdes_pkg::SAMPLE_W-1:0] s);
    longint x, half, span, fwd, rev, sgn, lim, cleaned, throttle;
    shape_t r;
    x    = longint'(s) - longint'(center_q);
    half = longint'(dz_q) / 2;
    span = longint'(fs_q) / 2 - (longint'(dz_q) * 3) / 2;
    fwd  = longint'(fwd_q);
    rev  = longint'(rev_q);
    r    = '0;
    if (span <= 0 || fwd == 0 || rev == 0) begin
      r.bad = 1'b1;
      return r;
    end
    sgn = (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    if (x * sgn < half) begin
      cleaned = 0;
    end else begin
      x = x - half * sgn;
      if (x * sgn > span) begin
        cleaned = fwd * sgn;
      end else begin
        cleaned = x * fwd / span;
      end
    end
    lim      = (cleaned < 0) ? rev : fwd;
    throttle = ((cleaned * cleaned / lim) * 2 + cleaned) / 3;
    r.cleaned  = cleaned[tdes_pkg::CLEAN_W-1:0];
    r.throttle = throttle[tdes_pkg::THR_W-1:0];
    return r;
  endfunction

  // Favors the ends of a range so that the extremes come up often.
  function automatic int unsigned pick_in(int unsigned lo, int unsigned hi);
    case ($urandom_range(7, 0))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Picks a uniform sample, a dead zone or saturation edge, or one around the active range.
  function automatic logic [tdes_pkg::SAMPLE_W-1:0] pick_sample();
    longint half, span, reach, off, v;
    half = longint'(dz_q) / 2;
    span = longint'(fs_q) / 2 - (longint'(dz_q) * 3) / 2;
    if (span < 1) span = 1;
    reach = half + span;
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(65535, 0));
      1: begin
        case ($urandom_range(3, 0))
          0: off = half - 1;
          1: off = half;
          2: off = reach;
          default: off = reach + 1;
        endcase
        if ($urandom_range(1, 0)) off = -off;
      end
      default: off = longint'($urandom_range(int'(2 * reach + 64), 0)) - (reach + 32);
    endcase
    v = longint'(center_q) + off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[tdes_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic write_reg(logic [tdes_pkg::IDX_W-1:0] idx, logic [tdes_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      tdes_pkg::REG_CENTER:     center_q = data;
      tdes_pkg::REG_DEAD_ZONE:  dz_q     = data;
      tdes_pkg::REG_FULL_SCALE: fs_q     = data;
      tdes_pkg::REG_FWD_LIMIT:  fwd_q    = data[tdes_pkg::LIMIT_W-1:0];
      tdes_pkg::REG_REV_LIMIT:  rev_q    = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(logic [tdes_pkg::CFG_W-1:0] center,
                             logic [tdes_pkg::CFG_W-1:0] zone,
                             logic [tdes_pkg::CFG_W-1:0] scale,
                             logic [tdes_pkg::LIMIT_W-1:0] fwd,
                             logic signed [tdes_pkg::CFG_W-1:0] rev);
    write_reg(tdes_pkg::REG_CENTER, center);
    write_reg(tdes_pkg::REG_DEAD_ZONE, zone);
    write_reg(tdes_pkg::REG_FULL_SCALE, scale);
    // The top data bit is not part of the forward limit; toggle it anyway.
    write_reg(tdes_pkg::REG_FWD_LIMIT, {1'($urandom_range(1, 0)), fwd});
    write_reg(tdes_pkg::REG_REV_LIMIT, rev);
    cfg_write <= 1'b0;
    n_settings++;
    @(posedge clk);
  endtask

  task automatic push_sample(logic [tdes_pkg::SAMPLE_W-1:0] s);
    int gap;
    shape_t want;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    want = shape_sample(s);
    pending_shapes.push_back(want);
    n_sent++;
    if (want.bad) begin
      n_bad++;
    end else if (want.cleaned == 0) begin
      n_zero++;
    end else if (want.cleaned == $signed({1'b0, fwd_q}) ||
                 want.cleaned == -$signed({1'b0, fwd_q})) begin
      n_sat++;
    end
  endtask

  // Waits until every expected result has come back, so registers may be written.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_shapes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_values();
    push_sample(16'd0);
    push_sample(16'd2048);
    push_sample(16'd4095);
    push_sample(16'hFFFF);
  endtask

  // Zone half width 50, span 1897: probe both sides of the zone boundary.
  task automatic test_dead_zone_edges();
    settle();
    load_config(16'd2048, 16'd100, 16'd4095, 15'd1000, -16'sd1000);
    push_sample(16'd1999);
    push_sample(16'd2097);
    push_sample(16'd1998);
    push_sample(16'd2098);
    push_sample(16'd2099);
    push_sample(16'd1997);
  endtask

  task automatic test_saturation_edges();
    // Same setting: the shrunk value reaches the span at an offset of 1947.
    push_sample(16'd3995);
    push_sample(16'd3996);
    push_sample(16'd101);
    push_sample(16'd100);
    settle();
    load_config(16'd0, 16'd0, 16'hFFFF, 15'h7FFF, 16'sh8000);
    push_sample(16'd0);
    push_sample(16'hFFFF);
    settle();
    load_config(16'hFFFF, 16'd0, 16'hFFFF, 15'h7FFF, -16'sd32767);
    push_sample(16'd0);
  endtask

  task automatic test_bad_config();
    settle();
    load_config(16'd2048, 16'd0, 16'd1, 15'd1000, -16'sd1000);
    push_sample(16'd2048);
    // A span of one is still legal; one more zone step makes it zero.
    settle();
    load_config(16'd2048, 16'd2730, 16'd8192, 15'd1000, -16'sd1000);
    push_sample(16'd4000);
    settle();
    load_config(16'd2048, 16'd2731, 16'd8192, 15'd1000, -16'sd1000);
    push_sample(16'd2048);
    settle();
    load_config(16'd2048, 16'd0, 16'd4095, 15'd0, -16'sd1000);
    push_sample(16'd3000);
    settle();
    load_config(16'd2048, 16'd0, 16'd4095, 15'd1000, 16'sd0);
    push_sample(16'd1000);
  endtask

  // A positive reverse limit flips the sign of the curve term for negative values.
  task automatic test_reverse_limit_sign();
    settle();
    load_config(16'd2048, 16'd0, 16'd4095, 15'd1000, 16'sd1);
    push_sample(16'd0);
    settle();
    load_config(16'd2048, 16'd0, 16'd4095, 15'd1000, 16'sd32767);
    push_sample(16'd1024);
  endtask

  task automatic test_spare_index();
    settle();
    for (int idx = int'(IDX_SPARE_FIRST); idx <= int'(IDX_SPARE_LAST); idx++) begin
      write_reg(idx[tdes_pkg::IDX_W-1:0], 16'hFFFF);
      write_reg(idx[tdes_pkg::IDX_W-1:0], 16'h0000);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
    push_sample(16'd500);
  endtask

  task automatic test_random_phases();
    logic [tdes_pkg::CFG_W-1:0]   center, zone, scale;
    logic [tdes_pkg::LIMIT_W-1:0] fwd;
    logic [tdes_pkg::CFG_W-1:0]   rev;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      in_gap_max  = (phase % 3 == 0) ? 0 : GAP_MAX;
      out_gap_max = (phase % 4 == 1) ? 0 : GAP_MAX;
      center = 16'(pick_in(0, 65535));
      scale  = 16'(pick_in(1, 65535));
      if ($urandom_range(7, 0) == 0) begin
        zone = 16'(pick_in(0, 65535));
      end else begin
        zone = 16'(pick_in(0, 32'(scale) / 3));
      end
      fwd = ($urandom_range(15, 0) == 0) ? 15'd0 : 15'(pick_in(1, 32767));
      if ($urandom_range(15, 0) == 0) begin
        rev = 16'($urandom_range(65535, 0));
      end else begin
        rev = 16'(-pick_in(1, 32767));
      end
      load_config(center, zone, scale, fwd, rev);
      repeat (PHASE_ITEMS) push_sample(pick_sample());
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen_shape = '{cleaned_value, throttle_value, bad_config};
        n_checked++;
        if (pending_shapes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result cleaned %0d throttle %0d bad %0b", $time,
                     seen_shape.cleaned, seen_shape.throttle, seen_shape.bad);
          end
        end else begin
          want_shape = pending_shapes.pop_front();
          if (seen_shape.cleaned !== want_shape.cleaned ||
              seen_shape.throttle !== want_shape.throttle ||
              seen_shape.bad !== want_shape.bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d differs: expected cleaned %0d throttle %0d bad %0b",
                       $time, n_checked, want_shape.cleaned, want_shape.throttle,
                       want_shape.bad);
              $display("%0t:   got cleaned %0d throttle %0d bad %0b", $time,
                       seen_shape.cleaned, seen_shape.throttle, seen_shape.bad);
            end
          end
        end
        stall_left = $urandom_range(out_gap_max, 0);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Ends the run if neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("throttle_deadzone_expo_shaper: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_write = 1'b0;
    cfg_index = tdes_pkg::REG_CENTER;
    cfg_data  = '0;
    center_q  = tdes_pkg::CENTER_RST;
    dz_q      = tdes_pkg::DEAD_ZONE_RST;
    fs_q      = tdes_pkg::FULL_SCALE_RST;
    fwd_q     = tdes_pkg::FWD_LIMIT_RST;
    rev_q     = tdes_pkg::REV_LIMIT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_dead_zone_edges();
    test_saturation_edges();
    test_bad_config();
    test_reverse_limit_sign();
    test_spare_index();
    test_random_phases();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_shapes.size() != 0) mismatches++;

    $display("Shaped %0d samples under %0d register settings, %0d results checked.",
             n_sent, n_settings, n_checked);
    $display("Of these %0d had a bad setting, %0d fell to zero and %0d hit the limit.",
             n_bad, n_zero, n_sat);
    if (mismatches == 0) begin
      $display("throttle_deadzone_expo_shaper: match");
    end else begin
      $display("throttle_deadzone_expo_shaper: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/tdes_pkg.sv
hdl/tdes_div.sv
hdl/throttle_deadzone_expo_shaper.sv
sim/tb_throttle_deadzone_expo_shaper.sv
